// File: hw/rtl/dsv_pkg.sv
// Shared types, codes and helper functions of the date string validator.
`timescale 1ns / 1ps

package dsv_pkg;

    localparam int unsigned DAY_W   = 7;
    localparam int unsigned MONTH_W = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned POS_W   = 4;

    localparam logic [POS_W-1:0] POS_SAT  = 4'd11;
    localparam logic [POS_W-1:0] POS_LAST = 4'd9;
    localparam logic [POS_W-1:0] WORD_LEN = 4'd10;
    localparam logic [POS_W-1:0] SEP_POS0 = 4'd2;
    localparam logic [POS_W-1:0] SEP_POS1 = 4'd5;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2100;

    localparam logic [MONTH_W-1:0] MONTH_LAST = 7'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 7'd2;

    // Configuration register indexes.
    localparam logic CFG_YEAR_MIN = 1'b0;
    localparam logic CFG_YEAR_MAX = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FORMAT = 3'd1,
        ST_DIGIT  = 3'd2,
        ST_YEAR   = 3'd3,
        ST_MONTH  = 3'd4,
        ST_DAY    = 3'd5
    } t_status;

    // One finished word as the front part classifies it.
    typedef struct packed {
        logic               format_ok;
        logic               digits_ok;
        logic               leap;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_word;

    function automatic logic [YEAR_W-1:0] times10_plus(input logic [YEAR_W-1:0] x,
                                                       input logic [3:0] d);
        times10_plus = (x << 3) + (x << 1) + {{(YEAR_W-4){1'b0}}, d};
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        case (month)
            4'd2:                      month_days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
            default:                   month_days = 5'd31;
        endcase
    endfunction

endpackage

// File: hw/rtl/dsv_front.sv
// Front part: takes bytes, tracks position, accumulates digits and classifies each word.
`timescale 1ns / 1ps

module dsv_front import dsv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_byte,
    input  logic       i_word_end,
    output logic       o_word_valid,
    output t_word      o_word
);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [6:0]         r_year_hi, n_year_hi;
    logic [6:0]         r_year_lo, n_year_lo;
    logic               r_sep_ok, n_sep_ok;
    logic               r_dig_ok, n_dig_ok;

    logic       in_window;
    logic       at_sep;
    logic       is_digit;
    logic       take_digit;
    logic [3:0] digit;

    assign in_window  = r_pos < WORD_LEN;
    assign at_sep     = (r_pos == SEP_POS0) || (r_pos == SEP_POS1);
    assign is_digit   = (i_char_byte >= CHAR_ZERO) && (i_char_byte <= CHAR_NINE);
    assign take_digit = in_window && !at_sep && is_digit;
    assign digit      = i_char_byte[3:0];

    always_comb begin
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_year_hi = r_year_hi;
        n_year_lo = r_year_lo;
        n_sep_ok  = r_sep_ok && !(in_window && at_sep && (i_char_byte != CHAR_DOT));
        n_dig_ok  = r_dig_ok && !(in_window && !at_sep && !is_digit);
        n_pos     = (r_pos < POS_SAT) ? r_pos + 4'd1 : r_pos;
        if (take_digit) begin
            if (r_pos < SEP_POS0) begin
                n_day = DAY_W'(times10_plus(YEAR_W'(r_day), digit));
            end else if (r_pos < SEP_POS1) begin
                n_month = MONTH_W'(times10_plus(YEAR_W'(r_month), digit));
            end else begin
                n_year = times10_plus(r_year, digit);
                // The two halves of the year give the leap rule without a divider.
                if (r_pos < 4'd8) begin
                    n_year_hi = 7'(times10_plus(YEAR_W'(r_year_hi), digit));
                end else begin
                    n_year_lo = 7'(times10_plus(YEAR_W'(r_year_lo), digit));
                end
            end
        end
    end

    assign o_word_valid     = i_accept && i_word_end;
    assign o_word.format_ok = (r_pos == POS_LAST) && n_sep_ok;
    assign o_word.digits_ok = n_dig_ok;
    assign o_word.leap      = (n_year_lo == 7'd0) ? (n_year_hi[1:0] == 2'd0)
                                                  : (n_year_lo[1:0] == 2'd0);
    assign o_word.day       = n_day;
    assign o_word.month     = n_month;
    assign o_word.year      = n_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_word_end)) begin
            r_pos     <= '0;
            r_day     <= '0;
            r_month   <= '0;
            r_year    <= '0;
            r_year_hi <= '0;
            r_year_lo <= '0;
            r_sep_ok  <= 1'b1;
            r_dig_ok  <= 1'b1;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_day     <= n_day;
            r_month   <= n_month;
            r_year    <= n_year;
            r_year_hi <= n_year_hi;
            r_year_lo <= n_year_lo;
            r_sep_ok  <= n_sep_ok;
            r_dig_ok  <= n_dig_ok;
        end
    end

endmodule

// File: hw/rtl/dsv_fifo.sv
// Short register queue of classified words between the front and back parts.
`timescale 1ns / 1ps

module dsv_fifo import dsv_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_word i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_empty,
    output t_word o_rdata
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_word            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/dsv_back.sv
// Back part: judges each classified word and holds the result in an output register.
`timescale 1ns / 1ps

module dsv_back import dsv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [YEAR_W-1:0]  i_year_min,
    input  logic [YEAR_W-1:0]  i_year_max,
    input  logic               i_q_empty,
    input  t_word              i_q_word,
    output logic               o_q_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [2:0]         o_status,
    output logic [DAY_W-1:0]   o_day_value,
    output logic [MONTH_W-1:0] o_month_value,
    output logic [YEAR_W-1:0]  o_year_value
);

    logic               r_valid;
    t_status            r_status, n_status;
    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic [4:0]         day_limit;
    logic               take;

    assign take      = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd    = take;
    assign day_limit = month_days(i_q_word.month[3:0], i_q_word.leap);

    always_comb begin
        if (!i_q_word.format_ok) begin
            n_status = ST_FORMAT;
        end else if (!i_q_word.digits_ok) begin
            n_status = ST_DIGIT;
        end else if ((i_q_word.year < i_year_min) || (i_q_word.year > i_year_max)) begin
            n_status = ST_YEAR;
        end else if ((i_q_word.month == '0) || (i_q_word.month > MONTH_LAST)) begin
            n_status = ST_MONTH;
        end else if ((i_q_word.day == '0) || (i_q_word.day > DAY_W'(day_limit))) begin
            n_status = ST_DAY;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Decoded values are only passed on for a word that passes every check.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= n_status;
            r_day    <= (n_status == ST_OK) ? i_q_word.day   : '0;
            r_month  <= (n_status == ST_OK) ? i_q_word.month : '0;
            r_year   <= (n_status == ST_OK) ? i_q_word.year  : '0;
        end
    end

    assign o_empty       = !r_valid;
    assign o_status      = r_status;
    assign o_day_value   = r_day;
    assign o_month_value = r_month;
    assign o_year_value  = r_year;

endmodule

// File: hw/rtl/date_string_validator_core.sv
// Top level of the DD.MM.YYYY date string validator.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          i_char_byte, i_word_end
//   result    out        empty / pop          o_status, o_day_value, o_month_value,
//                                             o_year_value
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// One byte is taken every cycle while full is low; after the final byte of a word
// is taken, its result passes through the word queue, then the output register.
// full rises only when the word queue of QUEUE_DEPTH entries is full, which only
// happens when pop is held low; the result register then holds its item.
// Reset clears the word state and the queue and loads year_min 1900 and year_max 2100.
`timescale 1ns / 1ps

module date_string_validator_core import dsv_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_char_byte,
    input  logic               i_word_end,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic [DAY_W-1:0]   o_day_value,
    output logic [MONTH_W-1:0] o_month_value,
    output logic [YEAR_W-1:0]  o_year_value,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [YEAR_W-1:0]  i_cfg_wdata
);

    logic [YEAR_W-1:0] r_year_min, r_year_max;
    logic              accept;
    logic              word_valid;
    t_word             front_word, q_word;
    logic              q_empty, q_rd;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_min <= YEAR_MIN_RST;
            r_year_max <= YEAR_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_YEAR_MIN: r_year_min <= i_cfg_wdata;
                CFG_YEAR_MAX: r_year_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    dsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_byte  (i_char_byte),
        .i_word_end   (i_word_end),
        .o_word_valid (word_valid),
        .o_word       (front_word)
    );

    dsv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (word_valid),
        .i_wdata (front_word),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_rdata (q_word)
    );

    dsv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_year_min    (r_year_min),
        .i_year_max    (r_year_max),
        .i_q_empty     (q_empty),
        .i_q_word      (q_word),
        .o_q_rd        (q_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_status      (o_status),
        .o_day_value   (o_day_value),
        .o_month_value (o_month_value),
        .o_year_value  (o_year_value)
    );

endmodule

// File: hw/rtl/dsv_checker.sv
// Port-level assertions for the date string validator, bound to the top level.
`timescale 1ns / 1ps

module dsv_checker import dsv_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic [2:0]         o_status,
    input logic [DAY_W-1:0]   o_day_value,
    input logic [MONTH_W-1:0] o_month_value,
    input logic [YEAR_W-1:0]  o_year_value
);

    // No result may be offered straight after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result offered after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_year_value)))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != ST_OK)) |->
        ((o_day_value == '0) && (o_month_value == '0) && (o_year_value == '0)))
        else $error("failed item carries decoded values");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_OK)) |->
        ((o_month_value >= 7'd1) && (o_month_value <= 7'd12) &&
         (o_day_value >= 7'd1) && (o_day_value <= 7'd31)))
        else $error("accepted date out of calendar range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= ST_DAY))
        else $error("status code out of range");

endmodule

bind date_string_validator_core dsv_checker u_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the DD.MM.YYYY date string validator core.
`timescale 1ns / 1ps

module tb;
    import dsv_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_CHARS   = 195;
    localparam int DIR_ROWS      = 25;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int LIMIT_NS      = 600000 * 12;

    typedef struct packed {
        t_status            status;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date_result;

    typedef struct {
        int           alt_pos;
        logic [7:0]   alt_byte;
        bit           typed_in;
        t_date_result want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_char_byte = 8'h00;
    logic               i_word_end = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [2:0]         o_status;
    logic [DAY_W-1:0]   o_day_value;
    logic [MONTH_W-1:0] o_month_value;
    logic [YEAR_W-1:0]  o_year_value;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_YEAR_MIN;
    logic [YEAR_W-1:0]  i_cfg_wdata = '0;

    // Predictor state: the word being assembled and the year window.
    logic [POS_W-1:0]   w_pos;
    logic [DAY_W-1:0]   w_day;
    logic [MONTH_W-1:0] w_month;
    logic [YEAR_W-1:0]  w_year;
    logic               w_sep_ok;
    logic               w_dig_ok;
    logic [YEAR_W-1:0]  win_lo;
    logic [YEAR_W-1:0]  win_hi;

    t_date_result pending_dates[$];
    logic [7:0]   word_buf[$];
    int           mismatches = 0;
    bit           hold_req = 1'b0;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;

    string dir_text [DIR_ROWS] = '{
        "29.02.2000", "31.12.2100", "01.01.1900", "29.02.1900", "29.02.2024",
        "29.02.2023", "31.04.2011", "00.01.2000", "30.02.2000", "01.00.2000",
        "01.13.2000", "15.06.1899", "15.06.2101", "09.99.9999", "0a.01.2000",
        "1/.:1.2000", "01.01.2000", "01.01.2000", "01.01.2000", "01-01-2000",
        "ab-cd-efgh", "1.1.2000",   ".",          "01.01.20000", "01.01.2000abcdef"
    };

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{-1, 8'h00, 1'b1, '{ST_OK,     7'd29, 7'd2,  14'd2000}},
        '{-1, 8'h00, 1'b1, '{ST_OK,     7'd31, 7'd12, 14'd2100}},
        '{-1, 8'h00, 1'b1, '{ST_OK,     7'd1,  7'd1,  14'd1900}},
        '{-1, 8'h00, 1'b1, '{ST_DAY,    7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b0, '{ST_OK,     7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_DAY,    7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_DAY,    7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_DAY,    7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b0, '{ST_OK,     7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_MONTH,  7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_MONTH,  7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_YEAR,   7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_YEAR,   7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_YEAR,   7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_DIGIT,  7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_DIGIT,  7'd0,  7'd0,  14'd0}},
        '{ 0, 8'hB1, 1'b1, '{ST_DIGIT,  7'd0,  7'd0,  14'd0}},
        '{ 9, 8'hFF, 1'b1, '{ST_DIGIT,  7'd0,  7'd0,  14'd0}},
        '{ 2, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}},
        '{-1, 8'h00, 1'b1, '{ST_FORMAT, 7'd0,  7'd0,  14'd0}}
    };

    date_string_validator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_byte   (i_char_byte),
        .i_word_end    (i_word_end),
        .empty         (empty),
        .pop           (pop),
        .o_status      (o_status),
        .o_day_value   (o_day_value),
        .o_month_value (o_month_value),
        .o_year_value  (o_year_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_word();
        w_pos    = '0;
        w_day    = '0;
        w_month  = '0;
        w_year   = '0;
        w_sep_ok = 1'b1;
        w_dig_ok = 1'b1;
    endfunction

    function automatic int month_length(input logic [MONTH_W-1:0] m,
                                        input logic [YEAR_W-1:0] y);
        bit leap_year;
        leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            7'd2:                   return leap_year ? 29 : 28;
            7'd4, 7'd6, 7'd9, 7'd11: return 30;
            default:                return 31;
        endcase
    endfunction

    // Bytes past the tenth only move the position, which stops at its saturation value.
    function automatic void absorb_char(input logic [7:0] c);
        logic [3:0] digit;
        digit = c[3:0];
        if (w_pos < WORD_LEN) begin
            if (w_pos == SEP_POS0 || w_pos == SEP_POS1) begin
                if (c != CHAR_DOT) w_sep_ok = 1'b0;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (w_pos < SEP_POS0) w_day = w_day * 7'd10 + 7'(digit);
                else if (w_pos < SEP_POS1) w_month = w_month * 7'd10 + 7'(digit);
                else w_year = w_year * 14'd10 + 14'(digit);
            end else begin
                w_dig_ok = 1'b0;
            end
        end
        if (w_pos < POS_SAT) w_pos = w_pos + 4'd1;
    endfunction

    function automatic t_status word_verdict();
        if (w_pos != WORD_LEN || !w_sep_ok) return ST_FORMAT;
        if (!w_dig_ok) return ST_DIGIT;
        if (w_year < win_lo || w_year > win_hi) return ST_YEAR;
        if (w_month < 7'd1 || w_month > MONTH_LAST) return ST_MONTH;
        if (w_day < 7'd1 || int'(w_day) > month_length(w_month, w_year)) return ST_DAY;
        return ST_OK;
    endfunction

    function automatic t_date_result close_word();
        t_date_result res;
        res = '{word_verdict(), '0, '0, '0};
        if (res.status == ST_OK) begin
            res.day   = w_day;
            res.month = w_month;
            res.year  = w_year;
        end
        clear_word();
        return res;
    endfunction

    task automatic offer_char(input logic [7:0] c, input logic last, input bit typed_in,
                              input t_date_result want);
        int r;
        int gap;
        gap = 0;
        if (!tx_steady) begin
            r = $urandom_range(0, 99);
            if (r >= 92) gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_char_byte <= c;
        i_word_end  <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        absorb_char(c);
        if (last) begin
            if (typed_in) begin
                void'(close_word());
                pending_dates.push_back(want);
            end else begin
                pending_dates.push_back(close_word());
            end
        end
    endtask

    task automatic send_word(input bit typed_in, input t_date_result want);
        int k;
        for (k = 0; k < word_buf.size(); k++)
            offer_char(word_buf[k], k == word_buf.size() - 1, typed_in, want);
    endtask

    task automatic push_digits(input int value, input int n);
        int k;
        for (k = n - 1; k >= 0; k--)
            word_buf.push_back(CHAR_ZERO + 8'((value / (10 ** k)) % 10));
    endtask

    // Mostly well-formed dates with random content; the rest are corrupted,
    // wrongly sized or pure noise.
    task automatic compose_word();
        int kind;
        int r;
        int k;
        int len;
        int day_n;
        int month_n;
        int year_n;
        int hi;
        word_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            r = $urandom_range(0, 9);
            month_n = (r < 9) ? $urandom_range(1, 12) : $urandom_range(0, 99);
            r = $urandom_range(0, 9);
            if (r < 6) day_n = $urandom_range(1, 28);
            else if (r < 9) day_n = 23 + r;
            else day_n = $urandom_range(0, 99);
            hi = (win_hi > 14'd9999) ? 9999 : int'(win_hi);
            if (win_lo <= win_hi && win_lo <= 14'd9999 && $urandom_range(0, 4) != 0)
                year_n = $urandom_range(hi, int'(win_lo));
            else
                year_n = $urandom_range(0, 9999);
            if ($urandom_range(0, 7) == 0) year_n = year_n - year_n % 100;
            push_digits(day_n, 2);
            word_buf.push_back(CHAR_DOT);
            push_digits(month_n, 2);
            word_buf.push_back(CHAR_DOT);
            push_digits(year_n, 4);
            if (kind >= 62) word_buf[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
        end else if (kind < 88) begin
            len = $urandom_range(1, 15);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 9);
                if (r < 6) word_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                else if (r < 8) word_buf.push_back(CHAR_DOT);
                else word_buf.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++) word_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic set_year_window(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_YEAR_MIN;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_YEAR_MAX;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    // Waits for every outstanding result, then lets the pipeline empty out.
    task automatic settle();
        push <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int r;
        int k;
        int ph;
        int sent;
        logic [YEAR_W-1:0] lo_list [PHASES];
        logic [YEAR_W-1:0] hi_list [PHASES];
        t_date_result want;
        lo_list = '{14'd1900, 14'd0,    14'd2100, 14'd0, 14'd9999,  14'd0, 14'd0, 14'd1900};
        hi_list = '{14'd2100, 14'd9999, 14'd1900, 14'd0, 14'd16383, 14'd0, 14'd0, 14'd2100};
        for (ph = 5; ph < 7; ph++) begin
            lo_list[ph] = 14'($urandom_range(0, 9999));
            hi_list[ph] = 14'($urandom_range(0, 9999));
        end
        clear_word();
        win_lo = YEAR_MIN_RST;
        win_hi = YEAR_MAX_RST;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            word_buf.delete();
            for (k = 0; k < dir_text[r].len(); k++) word_buf.push_back(dir_text[r][k]);
            if (dir_rows[r].alt_pos >= 0) word_buf[dir_rows[r].alt_pos] = dir_rows[r].alt_byte;
            send_word(dir_rows[r].typed_in, dir_rows[r].want);
        end

        want = '{ST_OK, '0, '0, '0};
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            set_year_window(lo_list[ph], hi_list[ph]);
            // One phase keeps the sender busy against a long receiver hold so the
            // queue fills and full is raised; another runs with no idling at all.
            tx_steady = (ph == 2 || ph == 4);
            rx_steady = (ph == 4);
            hold_req  = (ph == 2);
            sent = 0;
            while (sent < PHASE_CHARS) begin
                compose_word();
                sent += word_buf.size();
                send_word(1'b0, want);
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
        settle();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : receiver
        int stall_left;
        int r;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (rx_steady) begin
                pop <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    pop <= 1'b1;
                end else begin
                    pop <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_date_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_dates.size() == 0) begin
                $error("result item with no word waiting: status %0d", o_status);
                mismatches++;
            end else begin
                want = pending_dates.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_day_value !== want.day) begin
                    $error("day_value: expected %0d, got %0d", want.day, o_day_value);
                    mismatches++;
                end
                if (o_month_value !== want.month) begin
                    $error("month_value: expected %0d, got %0d", want.month, o_month_value);
                    mismatches++;
                end
                if (o_year_value !== want.year) begin
                    $error("year_value: expected %0d, got %0d", want.year, o_year_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
